### design/sau_pkg.sv
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants for the sigmoid activation unit
// Request structs, stage structs, Q4.12 constants and the breakpoint table,
// which is built at elaboration from an exact integer evaluation.
// ----------------------------------------------------------------------------
package sau_pkg;

    // Number of linear segments over |x| in [0, 8)
    localparam int unsigned SEGMENTS   = 64;
    // Signed width the gradient saturates to
    localparam int unsigned DATA_WIDTH = 16;

    localparam int unsigned SEG_BITS   = $clog2(SEGMENTS);
    localparam int unsigned BPI_W      = $clog2(SEGMENTS + 1);
    localparam int unsigned FRAC_BITS  = 15;                  // 8.0 in Q4.12 is 2^15
    localparam int unsigned PROD_W     = FRAC_BITS + SEG_BITS;

    localparam logic [12:0] ONE_Q12    = 13'd4096;

    localparam logic signed [32:0] DW_MAX = (33'sd1 <<< (DATA_WIDTH - 1)) - 33'sd1;
    localparam logic signed [32:0] DW_MIN = -DW_MAX - 33'sd1;

    localparam logic [63:0] Q60_ONE = 64'd1 << 60;

    // Input request
    typedef struct packed {
        logic               func;
        logic signed [15:0] operand_a;
        logic signed [15:0] operand_b;
        logic               last_in;
    } sau_in_t;

    // Result request
    typedef struct packed {
        logic signed [15:0] result;
        logic               saturated;
        logic               last_out;
    } sau_out_t;

    // After decode and table lookup
    typedef struct packed {
        logic               func;
        logic               neg;
        logic               big;
        logic [12:0]        lo;
        logic [12:0]        diff;
        logic [14:0]        frac;
        logic signed [15:0] dy;
        logic [22:0]        gk;
        logic               last;
    } sau_s1_t;

    // After the shared multiplier
    typedef struct packed {
        logic               func;
        logic               neg;
        logic               big;
        logic [12:0]        lo;
        logic signed [39:0] prod;
        logic               last;
    } sau_s2_t;

    typedef logic [SEGMENTS:0][12:0] bp_table_t;

    // (a * b) >> 60, kept to 64 bits
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    // Unsigned 64-bit restoring division, only used while building the table
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // round(4096 / (1 + exp(-8k/SEGMENTS))) in Q60 integer arithmetic
    function automatic logic [12:0] bp_value(input int unsigned k);
        logic [63:0] u;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] d40;
        logic [63:0] q;
        logic [63:0] rnd;
        u    = div_u64({32'd0, k} << 55, 64'(SEGMENTS));   // t/256
        sum  = Q60_ONE;
        term = Q60_ONE;
        // Taylor series of exp(-t/256)
        for (int n = 1; n <= 14; n++) begin
            term = div_u64(mul_q60(term, u), 64'(n));
            if (n[0]) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        // Raise to the 256th power
        for (int n = 0; n < 8; n++) begin
            sum = mul_q60(sum, sum);
        end
        d40 = (Q60_ONE + sum + (64'd1 << 19)) >> 20;
        q   = div_u64(64'd1 << 53, d40);
        rnd = (q + 64'd1) >> 1;
        return rnd[12:0];
    endfunction

    function automatic bp_table_t build_bp_table();
        bp_table_t t;
        for (int unsigned k = 0; k <= SEGMENTS; k++) begin
            t[k] = bp_value(k);
        end
        return t;
    endfunction

    localparam bp_table_t BP_TABLE = build_bp_table();

endpackage

### design/sau_prep.sv
// ----------------------------------------------------------------------------
// sau_prep: front-end decode for the sigmoid activation unit
// Takes |x| apart into segment index and fraction, reads both breakpoints,
// and forms the clamped y * (1 - y) factor for the gradient path.
// ----------------------------------------------------------------------------
module sau_prep (
    input  sau_pkg::sau_in_t in_req,
    output sau_pkg::sau_s1_t s1
);
    import sau_pkg::*;

    logic [16:0]       ax;
    logic [16:0]       mag;
    logic [PROD_W-1:0] seg_pos;
    logic [BPI_W-1:0]  lo_idx;
    logic [BPI_W-1:0]  hi_idx;
    logic [12:0]       lo_val;
    logic [12:0]       hi_val;
    logic [12:0]       yc;
    logic [25:0]       gk_full;

    // Magnitude of x; -32768 maps to 32768
    always_comb begin
        ax  = {in_req.operand_a[15], in_req.operand_a};
        mag = in_req.operand_a[15] ? (17'd0 - ax) : ax;
    end

    // Segment index and position within the segment
    assign seg_pos = PROD_W'(mag[14:0]) * PROD_W'(SEGMENTS);
    assign lo_idx  = BPI_W'(seg_pos[PROD_W-1:FRAC_BITS]);
    assign hi_idx  = lo_idx + BPI_W'(1);
    assign lo_val  = BP_TABLE[lo_idx];
    assign hi_val  = BP_TABLE[hi_idx];

    // Clamp y to 0..1.0 and form y * (1 - y), at most 2^22
    always_comb begin
        if (in_req.operand_b[15]) begin
            yc = 13'd0;
        end else if (in_req.operand_b[14:0] > 15'(ONE_Q12)) begin
            yc = ONE_Q12;
        end else begin
            yc = in_req.operand_b[12:0];
        end
    end
    assign gk_full = 26'(yc) * 26'(ONE_Q12 - yc);

    always_comb begin
        s1.func = in_req.func;
        s1.neg  = in_req.operand_a[15];
        s1.big  = mag[15];
        s1.lo   = lo_val;
        s1.diff = hi_val - lo_val;
        s1.frac = seg_pos[FRAC_BITS-1:0];
        s1.dy   = in_req.operand_a;
        s1.gk   = gk_full[22:0];
        s1.last = in_req.last_in;
    end

endmodule

### design/sigmoid_activation_unit_core.sv
// ----------------------------------------------------------------------------
// sigmoid_activation_unit_core: Q4.12 logistic activation and its gradient
// Three-stage pipeline: decode and table lookup, one shared multiplier,
// then interpolation / shift-and-saturate into the output register.
// ----------------------------------------------------------------------------
// A request passes through s1_reg, s2_reg and out_reg before its result is valid.
// Throughput: one request per cycle; each stage holds under backpressure
// and empty stages fill while the output waits.
// Pacing is set by m_ready at the output; the single multiplier stage serves both modes.
// Reset (aresetn low, synchronous) empties all stages; no result is pending.
module sigmoid_activation_unit_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sau_pkg::sau_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output sau_pkg::sau_out_t m_payload
);
    import sau_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    logic     s2_valid_reg, s2_valid_next;
    logic     m_valid_reg,  m_valid_next;
    sau_s1_t  s1_reg, s1_next;
    sau_s2_t  s2_reg, s2_next;
    sau_out_t out_reg, out_next;
    logic     fwd_reg;

    logic     adv1, adv2, adv3;

    logic signed [15:0] mul_a;
    logic signed [23:0] mul_b;
    logic [13:0]        ysum;
    logic [12:0]        yv;
    logic signed [15:0] fwd_res;
    logic signed [32:0] v_ext;
    logic signed [32:0] clip;
    logic               sat;

    // Stage advance: a stage moves when empty or when the next one moves
    assign adv3    = !m_valid_reg || m_ready;
    assign adv2    = !s2_valid_reg || adv3;
    assign adv1    = !s1_valid_reg || adv2;
    assign s_ready = adv1;

    // Stage 1: decode and breakpoint lookup
    sau_prep u_prep (
        .in_req (s_payload),
        .s1     (s1_next)
    );

    // Stage 2: shared multiplier (diff * frac, or dy * y(1-y))
    always_comb begin
        if (s1_reg.func) begin
            mul_a = s1_reg.dy;
            mul_b = $signed({1'b0, s1_reg.gk});
        end else begin
            mul_a = $signed({3'b000, s1_reg.diff});
            mul_b = $signed({9'd0, s1_reg.frac});
        end
        s2_next.func = s1_reg.func;
        s2_next.neg  = s1_reg.neg;
        s2_next.big  = s1_reg.big;
        s2_next.lo   = s1_reg.lo;
        s2_next.prod = mul_a * mul_b;
        s2_next.last = s1_reg.last;
    end

    // Stage 3: forward interpolation and symmetry
    always_comb begin
        ysum    = 14'(s2_reg.lo) + 14'(s2_reg.prod[27:FRAC_BITS]);
        yv      = s2_reg.big ? ONE_Q12 : ysum[12:0];
        fwd_res = s2_reg.neg ? $signed(16'(ONE_Q12 - yv)) : $signed(16'(yv));
    end

    // Stage 3: gradient floor shift and saturation
    always_comb begin
        v_ext = {{17{s2_reg.prod[39]}}, s2_reg.prod[39:24]};
        if (v_ext > DW_MAX) begin
            clip = DW_MAX;
            sat  = 1'b1;
        end else if (v_ext < DW_MIN) begin
            clip = DW_MIN;
            sat  = 1'b1;
        end else begin
            clip = v_ext;
            sat  = 1'b0;
        end
    end

    always_comb begin
        out_next.result    = s2_reg.func ? clip[15:0] : fwd_res;
        out_next.saturated = s2_reg.func && sat;
        out_next.last_out  = s2_reg.last;
    end

    // Valid bits per stage
    always_comb begin
        s1_valid_next = adv1 ? s_valid      : s1_valid_reg;
        s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;
        m_valid_next  = adv3 ? s2_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_reg <= s1_next;
        end
        if (adv2) begin
            s2_reg <= s2_next;
        end
        if (adv3) begin
            out_reg <= out_next;
            fwd_reg <= !s2_reg.func;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = out_reg;

    // An empty output stage means the whole pipe can take a request
    a_ready_when_out_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready
    ) else $error("input stalled with empty output stage");

    // Accepted request occupies stage 1 on the next edge
    a_accept_fills_s1: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_valid_reg
    ) else $error("accepted request lost at stage 1");

    // Forward results stay within 0..1.0
    a_fwd_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg && fwd_reg |->
            (!m_payload.result[15] && (m_payload.result <= 16'sd4096)
             && !m_payload.saturated)
    ) else $error("forward result out of range");

    // Gradient cannot clip at this data width
    a_no_sat: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !m_payload.saturated
    ) else $error("unexpected gradient saturation");

endmodule
